// ----- src/jsu_pkg.sv -----
package jsu_pkg;

  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NO_QUOTE = 2'd0,
    ERR_BAD_ESC  = 2'd1,
    ERR_BAD_HEX  = 2'd2,
    ERR_UNTERM   = 2'd3
  } err_t;

  typedef enum logic [7:0] {
    M_IDLE  = 8'b0000_0001,
    M_BODY  = 8'b0000_0010,
    M_ESC   = 8'b0000_0100,
    M_HEX0  = 8'b0000_1000,
    M_HEX1  = 8'b0001_0000,
    M_HEX2  = 8'b0010_0000,
    M_HEX3  = 8'b0100_0000,
    M_DRAIN = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    err_t       err;
    logic       run_end;
  } word_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] UTF_1B_LIM = 16'h0080;
  localparam logic [15:0] UTF_2B_LIM = 16'h0800;
  localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF_CONT   = 8'h80;

  // bit 4 flags a valid digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, c[3:0]};
    else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

// ----- src/json_string_unescaper_unit.sv -----
// Streaming JSON string-literal decoder: one raw byte per word in, decoded UTF-8 bytes,
// done or error words out, the final word of each input byte flagged by out_run_end.
// Input bytes are taken one per cycle while in_stall is low; a byte that yields n result
// words holds the output register until all n are taken (a \u escape to three UTF-8 bytes
// yields three, four when the byte flagged last also leaves the literal open). The next
// byte that yields words waits while that group drains or while the output is stalled;
// bytes that yield none pass straight through. After done or error, bytes are swallowed
// up to the one flagged last, then a new literal starting with a quote is expected.
module json_string_unescaper_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic [1:0]          out_kind,
  output logic [1:0]          out_err_code,
  output logic                out_run_end
);
  import jsu_pkg::*;

  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  word_t [MAX_RES-1:0] dec_words;
  logic [CNT_W-1:0]    dec_cnt;
  logic                grp_free;
  logic                go;
  word_t               out_word;

  assign go       = s1_valid_r && ((dec_cnt == '0) || grp_free);
  assign in_stall = s1_valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  jsu_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .c     (s1_byte_r),
    .last  (s1_last_r),
    .words (dec_words),
    .cnt   (dec_cnt)
  );

  jsu_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go && (dec_cnt != '0)),
    .ld_words  (dec_words),
    .ld_cnt    (dec_cnt),
    .out_stall (out_stall),
    .free      (grp_free),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_byte     = out_word.data;
  assign out_kind     = out_word.kind;
  assign out_err_code = out_word.err;
  assign out_run_end  = out_word.run_end;

endmodule

// ----- src/jsu_decode.sv -----
module jsu_decode (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       go,
  input  logic [7:0]                                 c,
  input  logic                                       last,
  output jsu_pkg::word_t [jsu_pkg::MAX_RES-1:0]      words,
  output logic [jsu_pkg::CNT_W-1:0]                  cnt
);
  import jsu_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [11:0] acc_r, acc_nxt;

  always_comb begin
    logic [7:0]       d [3];
    logic [1:0]       k;
    logic             t_on;
    kind_t            t_kind;
    err_t             t_err;
    logic             closed;
    logic [4:0]       h;
    logic [15:0]      v;
    logic [CNT_W-1:0] n;

    d[0] = 8'h00; d[1] = 8'h00; d[2] = 8'h00;
    k = 2'd0;
    t_on = 1'b0;
    t_kind = KIND_DONE;
    t_err = ERR_NO_QUOTE;
    closed = 1'b0;
    h = hex_val(c);
    v = {acc_r, h[3:0]};
    mode_nxt = mode_r;
    acc_nxt = acc_r;

    case (mode_r)
      M_DRAIN: begin
        if (last) mode_nxt = M_IDLE;
      end
      M_IDLE: begin
        if (c != CH_QUOTE) begin
          t_on = 1'b1; t_kind = KIND_ERR; t_err = ERR_NO_QUOTE; closed = 1'b1;
        end else begin
          mode_nxt = M_BODY;
        end
      end
      M_BODY: begin
        if (c == CH_QUOTE) begin
          t_on = 1'b1; t_kind = KIND_DONE; closed = 1'b1;
        end else if (c == CH_BSL) begin
          mode_nxt = M_ESC;
        end else begin
          d[0] = c; k = 2'd1;
        end
      end
      M_ESC: begin
        k = 2'd1;
        mode_nxt = M_BODY;
        case (c)
          CH_QUOTE: d[0] = CH_QUOTE;
          CH_BSL:   d[0] = CH_BSL;
          CH_SLASH: d[0] = CH_SLASH;
          8'h6E:    d[0] = 8'h0A;
          8'h72:    d[0] = 8'h0D;
          8'h74:    d[0] = 8'h09;
          8'h62:    d[0] = 8'h08;
          8'h66:    d[0] = 8'h0C;
          CH_U: begin
            k = 2'd0; acc_nxt = 12'd0; mode_nxt = M_HEX0;
          end
          default: begin
            k = 2'd0; mode_nxt = mode_r;
            t_on = 1'b1; t_kind = KIND_ERR; t_err = ERR_BAD_ESC; closed = 1'b1;
          end
        endcase
      end
      M_HEX0, M_HEX1, M_HEX2, M_HEX3: begin
        if (!h[4]) begin
          t_on = 1'b1; t_kind = KIND_ERR; t_err = ERR_BAD_HEX; closed = 1'b1;
        end else if (mode_r == M_HEX3) begin
          acc_nxt = 12'd0;
          mode_nxt = M_BODY;
          if (v < UTF_1B_LIM) begin
            d[0] = v[7:0]; k = 2'd1;
          end else if (v < UTF_2B_LIM) begin
            d[0] = UTF_LEAD2 | {3'b000, v[10:6]};
            d[1] = UTF_CONT | {2'b00, v[5:0]};
            k = 2'd2;
          end else begin
            d[0] = UTF_LEAD3 | {4'h0, v[15:12]};
            d[1] = UTF_CONT | {2'b00, v[11:6]};
            d[2] = UTF_CONT | {2'b00, v[5:0]};
            k = 2'd3;
          end
        end else begin
          acc_nxt = {acc_r[7:0], h[3:0]};
          case (mode_r)
            M_HEX0:  mode_nxt = M_HEX1;
            M_HEX1:  mode_nxt = M_HEX2;
            default: mode_nxt = M_HEX3;
          endcase
        end
      end
      default: mode_nxt = M_IDLE;
    endcase

    if (mode_r != M_DRAIN) begin
      if (closed) begin
        mode_nxt = last ? M_IDLE : M_DRAIN;
        acc_nxt = 12'd0;
      end else if (last) begin
        t_on = 1'b1; t_kind = KIND_ERR; t_err = ERR_UNTERM;
        mode_nxt = M_IDLE;
        acc_nxt = 12'd0;
      end
    end

    n = CNT_W'(k) + CNT_W'(t_on);
    cnt = n;
    for (int i = 0; i < MAX_RES; i++) begin
      if (i < int'(k)) begin
        words[i].data = d[i < 3 ? i : 0];
        words[i].kind = KIND_DATA;
        words[i].err  = ERR_NO_QUOTE;
      end else begin
        words[i].data = 8'h00;
        words[i].kind = t_kind;
        words[i].err  = (t_kind == KIND_ERR) ? t_err : ERR_NO_QUOTE;
      end
      words[i].run_end = (i == int'(n) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= 12'd0;
    end else if (go) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ----- src/jsu_out.sv -----
module jsu_out (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  jsu_pkg::word_t [jsu_pkg::MAX_RES-1:0]  ld_words,
  input  logic [jsu_pkg::CNT_W-1:0]              ld_cnt,
  input  logic                                   out_stall,
  output logic                                   free,
  output logic                                   out_valid,
  output jsu_pkg::word_t                         out_word
);
  import jsu_pkg::*;

  word_t [MAX_RES-1:0] words_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                pop;

  assign out_valid = (cnt_r != '0);
  assign out_word  = words_r[0];
  assign pop       = out_valid && !out_stall;
  assign free      = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= ld_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words_r <= ld_words;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) words_r[i] <= words_r[i+1];
    end
  end

endmodule

// ----- test/json_unescape_checker.sv -----
`timescale 1ns / 1ps
module json_unescape_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic [1:0] out_kind,
  input  logic [1:0] out_err_code,
  input  logic       out_run_end,
  output int         fail_cnt,
  output int         pending
);
  import jsu_pkg::*;

  mode_t       dec_mode;
  logic [11:0] hex_acc;
  word_t       expected_words[$];

  // bit 4 set when c is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
    else return 5'd0;
    return {1'b1, d[3:0]};
  endfunction

  // bit 8 set when c is a one-byte escape
  function automatic logic [8:0] esc_byte(input logic [7:0] c);
    case (c)
      CH_QUOTE: return {1'b1, CH_QUOTE};
      CH_BSL:   return {1'b1, CH_BSL};
      CH_SLASH: return {1'b1, CH_SLASH};
      8'h6E:    return {1'b1, 8'h0A};
      8'h72:    return {1'b1, 8'h0D};
      8'h74:    return {1'b1, 8'h09};
      8'h62:    return {1'b1, 8'h08};
      8'h66:    return {1'b1, 8'h0C};
      default:  return 9'd0;
    endcase
  endfunction

  function automatic word_t mk_word(input logic [7:0] d, input kind_t k, input err_t e);
    word_t w;
    w.data    = d;
    w.kind    = k;
    w.err     = e;
    w.run_end = 1'b0;
    return w;
  endfunction

  task automatic decode_byte(input logic [7:0] c, input logic lst);
    word_t       grp[$];
    logic        closed;
    logic [4:0]  nib;
    logic [8:0]  esc;
    logic [15:0] v;
    closed = 1'b0;
    if (dec_mode == M_DRAIN) begin
      if (lst) dec_mode = M_IDLE;
      return;
    end
    case (dec_mode)
      M_IDLE: begin
        if (c != CH_QUOTE) begin
          grp = {grp, mk_word(8'h00, KIND_ERR, ERR_NO_QUOTE)};
          closed = 1'b1;
        end else begin
          dec_mode = M_BODY;
        end
      end
      M_BODY: begin
        if (c == CH_QUOTE) begin
          grp = {grp, mk_word(8'h00, KIND_DONE, ERR_NO_QUOTE)};
          closed = 1'b1;
        end else if (c == CH_BSL) begin
          dec_mode = M_ESC;
        end else begin
          grp = {grp, mk_word(c, KIND_DATA, ERR_NO_QUOTE)};
        end
      end
      M_ESC: begin
        esc = esc_byte(c);
        if (c == CH_U) begin
          hex_acc  = '0;
          dec_mode = M_HEX0;
        end else if (esc[8]) begin
          grp = {grp, mk_word(esc[7:0], KIND_DATA, ERR_NO_QUOTE)};
          dec_mode = M_BODY;
        end else begin
          grp = {grp, mk_word(8'h00, KIND_ERR, ERR_BAD_ESC)};
          closed = 1'b1;
        end
      end
      default: begin
        nib = hex_digit(c);
        if (!nib[4]) begin
          grp = {grp, mk_word(8'h00, KIND_ERR, ERR_BAD_HEX)};
          closed = 1'b1;
        end else if (dec_mode == M_HEX3) begin
          v = {hex_acc, nib[3:0]};
          if (v < UTF_1B_LIM) begin
            grp = {grp, mk_word(v[7:0], KIND_DATA, ERR_NO_QUOTE)};
          end else if (v < UTF_2B_LIM) begin
            grp = {grp, mk_word(UTF_LEAD2 | {3'b0, v[10:6]}, KIND_DATA, ERR_NO_QUOTE)};
            grp = {grp, mk_word(UTF_CONT | {2'b0, v[5:0]}, KIND_DATA, ERR_NO_QUOTE)};
          end else begin
            grp = {grp, mk_word(UTF_LEAD3 | {4'b0, v[15:12]}, KIND_DATA, ERR_NO_QUOTE)};
            grp = {grp, mk_word(UTF_CONT | {2'b0, v[11:6]}, KIND_DATA, ERR_NO_QUOTE)};
            grp = {grp, mk_word(UTF_CONT | {2'b0, v[5:0]}, KIND_DATA, ERR_NO_QUOTE)};
          end
          hex_acc  = '0;
          dec_mode = M_BODY;
        end else begin
          hex_acc  = {hex_acc[7:0], nib[3:0]};
          dec_mode = mode_t'(dec_mode << 1);
        end
      end
    endcase
    if (closed) begin
      dec_mode = lst ? M_IDLE : M_DRAIN;
      hex_acc  = '0;
    end else if (lst) begin
      grp = {grp, mk_word(8'h00, KIND_ERR, ERR_UNTERM)};
      dec_mode = M_IDLE;
      hex_acc  = '0;
    end
    if (grp.size() > 0) grp[grp.size() - 1].run_end = 1'b1;
    expected_words = {expected_words, grp};
  endtask

  always @(posedge clk) begin : monitor
    word_t w;
    logic  bad;
    if (!rst_n) begin
      dec_mode = M_IDLE;
      hex_acc  = '0;
      expected_words.delete();
      fail_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("out_kind: expected no word, got %0d (out_byte 8'h%02h)", out_kind, out_byte);
          fail_cnt++;
        end else begin
          w   = expected_words.pop_front();
          bad = 1'b0;
          if (out_byte !== w.data) begin
            $error("out_byte: expected 8'h%02h, got 8'h%02h", w.data, out_byte);
            bad = 1'b1;
          end
          if (out_kind !== w.kind) begin
            $error("out_kind: expected %0d, got %0d", w.kind, out_kind);
            bad = 1'b1;
          end
          if (out_err_code !== w.err) begin
            $error("out_err_code: expected %0d, got %0d", w.err, out_err_code);
            bad = 1'b1;
          end
          if (out_run_end !== w.run_end) begin
            $error("out_run_end: expected %0d, got %0d", w.run_end, out_run_end);
            bad = 1'b1;
          end
          if (bad) fail_cnt++;
        end
      end
      if (in_valid && !in_stall) decode_byte(in_byte, in_last);
    end
    pending = expected_words.size();
  end

endmodule

// ----- test/json_string_unescaper_unit_tb.sv -----
`timescale 1ns / 1ps
module json_string_unescaper_unit_tb;
  import jsu_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 20;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [1:0] out_err_code;
  logic       out_run_end;

  int fail_cnt;
  int pending;
  int idle_pct;
  int stall_pct;
  int quiet;
  int n_items;
  int n_words;
  int n_lits;
  int n_broken;
  int phase_items;

  logic [7:0] buf_q[$];

  json_string_unescaper_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_err_code (out_err_code),
    .out_run_end  (out_run_end)
  );

  json_unescape_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_err_code (out_err_code),
    .out_run_end  (out_run_end),
    .fail_cnt     (fail_cnt),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (out_valid && !out_stall) n_words++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] base;
    if (n < 4'd10) return 8'h30 + n;
    base = $urandom_range(1) ? 8'h41 : 8'h61;
    return base + n - 8'd10;
  endfunction

  function automatic logic [7:0] esc_letter(input int i);
    case (i)
      0:       return CH_QUOTE;
      1:       return CH_BSL;
      2:       return CH_SLASH;
      3:       return 8'h62;
      4:       return 8'h66;
      5:       return 8'h6E;
      6:       return 8'h72;
      default: return 8'h74;
    endcase
  endfunction

  function automatic logic is_escape_letter(input logic [7:0] b);
    return b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == CH_U || b == 8'h62 ||
           b == 8'h66 || b == 8'h6E || b == 8'h72 || b == 8'h74;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    buf_q = {buf_q, b};
  endtask

  task automatic send_word(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_buffer;
    for (int i = 0; i < buf_q.size(); i++) send_word(buf_q[i], i == buf_q.size() - 1);
    n_items     += buf_q.size();
    phase_items += buf_q.size();
  endtask

  task automatic add_u_escape(input logic [15:0] v, input int ndig);
    put_byte(CH_BSL);
    put_byte(CH_U);
    for (int k = 0; k < ndig; k++) put_byte(hex_char(v[15 - 4 * k -: 4]));
  endtask

  task automatic add_junk(input int n);
    repeat (n) put_byte(8'($urandom_range(255)));
  endtask

  task automatic add_element;
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSL);
        put_byte(b);
      end
      4, 5, 6: begin
        put_byte(CH_BSL);
        put_byte(esc_letter(int'($urandom_range(7))));
      end
      default: begin
        case ($urandom_range(2))
          0:       v = 16'($urandom_range(16'h7F));
          1:       v = 16'($urandom_range(16'h7FF, 16'h80));
          default: v = 16'($urandom_range(16'hFFFF, 16'h800));
        endcase
        add_u_escape(v, 4);
      end
    endcase
  endtask

  // mostly well-formed literals, the rest broken in one of the ways the decoder flags
  task automatic make_literal;
    int         r;
    logic [7:0] b;
    buf_q.delete();
    r = $urandom_range(99);
    n_lits++;
    if (r >= 65) n_broken++;
    if (r < 65) begin
      put_byte(CH_QUOTE);
      repeat ($urandom_range(6)) add_element();
      put_byte(CH_QUOTE);
      if ($urandom_range(3) == 0) add_junk($urandom_range(3, 1));
    end else if (r < 73) begin
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
      put_byte(b);
      add_junk($urandom_range(2));
    end else if (r < 81) begin
      put_byte(CH_QUOTE);
      repeat ($urandom_range(2)) add_element();
      put_byte(CH_BSL);
      do b = 8'($urandom_range(255)); while (is_escape_letter(b));
      put_byte(b);
      add_junk($urandom_range(2));
    end else if (r < 89) begin
      put_byte(CH_QUOTE);
      repeat ($urandom_range(2)) add_element();
      put_byte(CH_BSL);
      put_byte(CH_U);
      repeat ($urandom_range(3)) put_byte(hex_char(4'($urandom_range(15))));
      do b = 8'($urandom_range(255)); while (is_hex(b));
      put_byte(b);
      add_junk($urandom_range(2));
    end else begin
      put_byte(CH_QUOTE);
      repeat ($urandom_range(3)) add_element();
      case ($urandom_range(2))
        1:       put_byte(CH_BSL);
        2:       add_u_escape(16'($urandom_range(16'hFFFF)), int'($urandom_range(3, 1)));
        default: ;
      endcase
    end
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall);
    idle_pct    = idle;
    stall_pct   = stall;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      make_literal();
      send_buffer();
    end
    settle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    in_last   = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // byte extremes, \u0800 cut off by last: three UTF-8 bytes then unterminated
    buf_q = '{CH_QUOTE, 8'h00, 8'hFF, CH_BSL, CH_U, 8'h30, 8'h38, 8'h30, 8'h30};
    send_buffer();
    buf_q = '{8'h71, 8'h61};
    send_buffer();
    buf_q = '{CH_QUOTE, CH_BSL, 8'h78, 8'h79};
    send_buffer();
    buf_q = '{CH_QUOTE, CH_BSL, CH_U, 8'h31, 8'h67};
    send_buffer();
    buf_q = '{CH_QUOTE};
    send_buffer();
    buf_q = '{CH_QUOTE, CH_BSL};
    send_buffer();
    buf_q = '{CH_QUOTE, CH_QUOTE};
    send_buffer();
    buf_q = '{CH_QUOTE, 8'h41, CH_QUOTE, CH_QUOTE};
    send_buffer();
    settle();

    run_phase(0, 0);
    run_phase(64, 0);
    run_phase(0, 64);
    run_phase(15, 15);

    $display("Sent %0d bytes (%0d random literals, %0d malformed), checked %0d words,",
             n_items, n_lits, n_broken, n_words);
    $display("with sender gaps and output stalls at 0, 15 and 64 percent.");
    if (fail_cnt == 0 && pending == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
